### hdl/dtq_pkg.sv
package dtq_pkg;

    localparam int TICK_W         = 48;
    localparam int HANDLE_W       = 16;
    localparam int DELAY_W        = 32;
    localparam int MAX_BURST      = 16;
    localparam int BURST_W        = $clog2(MAX_BURST + 1);
    localparam int CMD_FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_SCHED,
        OP_REJECT,
        OP_TICK
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS   = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_IDLE     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_FULL       = 2'd1,
        ST_ZERO_DELAY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCHED,
        BK_TICK
    } back_state_t;

    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] handle;
        logic [DELAY_W-1:0]  delay;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_link_t;

    typedef struct packed {
        kind_t               kind;
        status_t             status;
        logic                became_head;
        logic [HANDLE_W-1:0] handle;
        logic                last;
    } result_t;

endpackage

### hdl/dtq_if.sv
interface dtq_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] job_handle;
    logic [31:0] delay_ticks;

    modport source (output valid, func, job_handle, delay_ticks, input ready);
    modport sink   (input valid, func, job_handle, delay_ticks, output ready);
endinterface

interface dtq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        became_head;
    logic [15:0] dispatched_handle;
    logic        last;

    modport source (output valid, kind, status, became_head, dispatched_handle, last,
                    input ready);
    modport sink   (input valid, kind, status, became_head, dispatched_handle, last,
                    output ready);
endinterface

### hdl/dtq_front.sv
module dtq_front (
    input  logic                clk,
    input  logic                rst_n,
    dtq_req_if.sink             req,
    output dtq_pkg::cmd_link_t  cmd_link,
    input  logic                cmd_pop
);
    import dtq_pkg::*;

    localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
    localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

    cmd_t             mem [CMD_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    cmd_t             new_cmd;

    assign req.ready = (cnt_reg != CNT_W'(CMD_FIFO_DEPTH));
    assign push      = req.valid && req.ready;

    // classify: zero delay is rejected here, the full check needs the table
    always_comb
    begin
        new_cmd.handle = req.job_handle;
        new_cmd.delay  = req.delay_ticks;
        if (req.func)
        begin
            new_cmd.op = OP_TICK;
        end
        else if (req.delay_ticks == '0)
        begin
            new_cmd.op = OP_REJECT;
        end
        else
        begin
            new_cmd.op = OP_SCHED;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= new_cmd;
        end
    end

    assign cmd_link.valid = (cnt_reg != '0);
    assign cmd_link.cmd   = mem[rd_ptr_reg];

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cnt_reg != '0)
        else $error("command queue popped while empty");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CMD_FIFO_DEPTH))
        else $error("command queue count out of range");
`endif

endmodule

### hdl/dtq_back.sv
module dtq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dtq_pkg::cmd_link_t  cmd_link,
    output logic                cmd_pop,
    dtq_rsp_if.source           rsp
);
    import dtq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    back_state_t         state_reg, state_next;
    logic [TICK_W-1:0]   now_reg, now_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [BURST_W-1:0]  burst_reg, burst_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg;

    logic [TICK_W-1:0]   dl_reg;
    logic [HANDLE_W-1:0] handle_reg;
    op_t                 op_reg;

    logic [TICK_W-1:0]   dl_arr [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] hd_arr [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] le;

    logic    out_free;
    logic    due0;
    logic    due1;
    logic    full;
    logic    do_ins;
    logic    do_pop;
    logic    load_out;
    result_t res;

    assign out_free = !out_valid_reg || rsp.ready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign due0     = (count_reg != '0) && (dl_arr[0] <= now_reg);
    assign due1     = (count_reg > CNT_W'(1)) && (dl_arr[1] <= now_reg);

    // le marks live entries that stay ahead of the new deadline
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_le
        assign le[i] = (CNT_W'(i) < count_reg) && (dl_arr[i] <= dl_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_link.valid)
                begin
                    state_next = (cmd_link.cmd.op == OP_TICK) ? BK_TICK : BK_SCHED;
                end
            end
            BK_SCHED:
            begin
                if (load_out)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_TICK:
            begin
                if (load_out && res.last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop         = 1'b0;
        do_ins          = 1'b0;
        do_pop          = 1'b0;
        load_out        = 1'b0;
        res.kind        = KIND_STATUS;
        res.status      = ST_ACCEPTED;
        res.became_head = 1'b0;
        res.handle      = '0;
        res.last        = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_pop = cmd_link.valid;
            end
            BK_SCHED:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (op_reg == OP_REJECT)
                    begin
                        res.status = ST_ZERO_DELAY;
                    end
                    else if (full)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        do_ins          = 1'b1;
                        res.became_head = !le[0];
                    end
                end
            end
            BK_TICK:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (due0)
                    begin
                        do_pop     = 1'b1;
                        res.kind   = KIND_DISPATCH;
                        res.handle = hd_arr[0];
                        res.last   = !(due1 && (burst_reg != BURST_W'(MAX_BURST - 1)));
                    end
                    else
                    begin
                        res.kind = KIND_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        now_next       = now_reg;
        count_next     = count_reg;
        burst_next     = burst_reg;
        out_valid_next = out_valid_reg;
        if (cmd_pop && (cmd_link.cmd.op == OP_TICK))
        begin
            now_next = now_reg + 1'b1;
        end
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd_pop)
        begin
            burst_next = '0;
        end
        else if (do_pop)
        begin
            burst_next = burst_reg + 1'b1;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            now_reg       <= '0;
            count_reg     <= '0;
            burst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            count_reg     <= count_next;
            burst_reg     <= burst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            op_reg     <= cmd_link.cmd.op;
            handle_reg <= cmd_link.cmd.handle;
            dl_reg     <= now_reg + TICK_W'(cmd_link.cmd.delay);
        end
        if (load_out)
        begin
            out_res_reg <= res;
        end
    end

    // each cell either takes the new entry, takes its lower neighbor on an
    // insert, or takes its upper neighbor when the head leaves
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [TICK_W-1:0]   in_dl;
        logic [HANDLE_W-1:0] in_hd;
        logic [TICK_W-1:0]   up_dl;
        logic [HANDLE_W-1:0] up_hd;

        if (i == 0)
        begin : g_first
            assign in_dl = dl_reg;
            assign in_hd = handle_reg;
        end
        else
        begin : g_rest
            assign in_dl = le[i-1] ? dl_reg : dl_arr[i-1];
            assign in_hd = le[i-1] ? handle_reg : hd_arr[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_top
            assign up_dl = dl_arr[i];
            assign up_hd = hd_arr[i];
        end
        else
        begin : g_mid
            assign up_dl = dl_arr[i+1];
            assign up_hd = hd_arr[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (do_ins)
            begin
                if (!le[i])
                begin
                    dl_arr[i] <= in_dl;
                    hd_arr[i] <= in_hd;
                end
            end
            else if (do_pop)
            begin
                dl_arr[i] <= up_dl;
                hd_arr[i] <= up_hd;
            end
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.kind              = out_res_reg.kind;
    assign rsp.status            = out_res_reg.status;
    assign rsp.became_head       = out_res_reg.became_head;
    assign rsp.dispatched_handle = out_res_reg.handle;
    assign rsp.last              = out_res_reg.last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above table depth");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> dl_arr[0] <= dl_arr[1])
        else $error("head entries out of deadline order");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            $past(state_reg) == BK_SCHED || $past(state_reg) == BK_TICK)
        else $error("entry count changed outside schedule or tick work");

    a_now_change: assert property (@(posedge clk) disable iff (!rst_n)
        now_reg != $past(now_reg) |->
            $past(cmd_pop) && $past(cmd_link.cmd.op) == OP_TICK)
        else $error("tick counter moved without a tick command");
`endif

endmodule

### hdl/deadline_timer_queue.sv
// deadline_timer_queue: sorted table of pending job handles plus a tick counter.
// req channel (valid/ready): func 0 schedules job_handle due delay_ticks after
// now, func 1 advances time by one tick. rsp channel (valid/ready) returns one
// status result per schedule item (accepted, table full, zero delay) with
// became_head, and per tick either one idle result or up to 16 dispatched
// handles in deadline order, the final one with last set.
// a 4-entry command queue sits between the input side and the table engine,
// so req keeps taking items while a result waits on rsp.
// a request passes the command queue, the engine command registers and the
// output register on its way to rsp; the engine takes one command at a time.
// the table inserts or removes one entry per cycle while rsp does not stall;
// a tick item yields one idle result or one result per dispatched handle.
// when rsp stalls the engine holds its result in the output register and
// stops; req stalls once the command queue fills.
// reset: time is zero, the table and command queue are empty, rsp.valid low.
module deadline_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    dtq_req_if.sink   req,
    dtq_rsp_if.source rsp
);
    import dtq_pkg::*;

    cmd_link_t cmd_link;
    logic      cmd_pop;

    dtq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd_link (cmd_link),
        .cmd_pop  (cmd_pop)
    );

    dtq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_link (cmd_link),
        .cmd_pop  (cmd_pop),
        .rsp      (rsp)
    );

endmodule

### bench/deadline_timer_queue_tb.sv
module deadline_timer_queue_tb;

    import dtq_pkg::*;

    localparam int          QUEUE_DEPTH     = 16;
    localparam int          IDLE_PCT        = 16;
    localparam int          RSP_HOLD_CYCLES = 200;
    localparam int          QUIET_LIMIT     = 2000;
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          MAX_PRINTED     = 40;
    localparam int          LONG_WAIT_MAX   = 3;
    localparam logic        FUNC_SCHEDULE   = 1'b0;
    localparam logic        FUNC_TICK       = 1'b1;
    localparam logic [31:0] DELAY_NONE      = 32'd0;
    localparam logic [31:0] DELAY_MAX       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                func;
        logic [HANDLE_W-1:0] handle;
        logic [DELAY_W-1:0]  delay;
    } timer_req_t;

    logic clk = 1'b0;
    logic rst_n;

    dtq_req_if req ();
    dtq_rsp_if rsp ();

    deadline_timer_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    always #4 clk = ~clk;

    // shadow of the timer table, kept in step with accepted transfers
    logic [TICK_W-1:0]   tick_now;
    logic [TICK_W-1:0]   slot_deadline [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] slot_handle   [QUEUE_DEPTH];
    int                  slot_count;
    result_t             awaited_results [$];

    timer_req_t  outbox [$];
    int unsigned queued_items;
    int unsigned accepted_items;
    int unsigned error_count;
    int unsigned long_waits;
    bit          no_idle;
    bit          hold_rsp;

    function automatic void update_timer_table(logic func, logic [HANDLE_W-1:0] handle,
                                               logic [DELAY_W-1:0] delay);
        result_t           res;
        logic [TICK_W-1:0] deadline;
        int                pos;
        int                due;
        res      = '0;
        res.last = 1'b1;
        if (func == FUNC_SCHEDULE)
        begin
            res.kind = KIND_STATUS;
            if (delay == DELAY_NONE)
            begin
                res.status = ST_ZERO_DELAY;
            end
            else if (slot_count >= QUEUE_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                deadline = tick_now + TICK_W'(delay);
                pos = 0;
                // equal deadlines keep arrival order
                while (pos < slot_count && slot_deadline[pos] <= deadline)
                    pos++;
                for (int i = slot_count; i > pos; i--)
                begin
                    slot_deadline[i] = slot_deadline[i-1];
                    slot_handle[i]   = slot_handle[i-1];
                end
                slot_deadline[pos] = deadline;
                slot_handle[pos]   = handle;
                slot_count++;
                res.status      = ST_ACCEPTED;
                res.became_head = (pos == 0);
            end
            awaited_results.push_back(res);
        end
        else
        begin
            tick_now = tick_now + 1'b1;
            due = 0;
            while (due < slot_count && due < MAX_BURST && slot_deadline[due] <= tick_now)
                due++;
            if (due == 0)
            begin
                res.kind = KIND_IDLE;
                awaited_results.push_back(res);
            end
            for (int i = 0; i < due; i++)
            begin
                res.kind   = KIND_DISPATCH;
                res.handle = slot_handle[i];
                res.last   = (i == due - 1);
                awaited_results.push_back(res);
            end
            for (int i = due; i < slot_count; i++)
            begin
                slot_deadline[i-due] = slot_deadline[i];
                slot_handle[i-due]   = slot_handle[i];
            end
            slot_count -= due;
        end
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // request driver: one new item or idle per falling edge once the last is taken, table update on each transfer
    initial
    begin : drive_req
        bit         took;
        timer_req_t item;
        req.valid       = 1'b0;
        req.func        = FUNC_SCHEDULE;
        req.job_handle  = '0;
        req.delay_ticks = '0;
        forever
        begin
            @(posedge clk);
            took = (req.valid === 1'b1) && (req.ready === 1'b1);
            if (took)
            begin
                update_timer_table(req.func, req.job_handle, req.delay_ticks);
                accepted_items++;
            end
            @(negedge clk);
            if (took || !req.valid)
            begin
                if (outbox.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
                begin
                    item = outbox.pop_front();
                    req.valid       <= 1'b1;
                    req.func        <= item.func;
                    req.job_handle  <= item.handle;
                    req.delay_ticks <= item.delay;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    initial
    begin : drive_rsp_ready
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                rsp.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d handle %h",
                                          rsp.kind, rsp.dispatched_handle));
            end
            else
            begin
                want = awaited_results.pop_front();
                if (rsp.kind !== want.kind)
                    report_mismatch($sformatf("kind got %0d want %0d", rsp.kind, want.kind));
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp.status, want.status));
                if (rsp.became_head !== want.became_head)
                    report_mismatch($sformatf("became_head got %0b want %0b",
                                              rsp.became_head, want.became_head));
                if (rsp.dispatched_handle !== want.handle)
                    report_mismatch($sformatf("handle got %h want %h",
                                              rsp.dispatched_handle, want.handle));
                if (rsp.last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b", rsp.last, want.last));
            end
        end
    end

    // ends the run if neither channel sees a transfer for too long
    always @(posedge clk)
    begin : watchdog
        int unsigned quiet;
        if ((req.valid === 1'b1 && req.ready === 1'b1) ||
            (rsp.valid === 1'b1 && rsp.ready === 1'b1))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("deadline_timer_queue verification failed");
            $finish;
        end
    end

    task automatic send_item(logic func, logic [HANDLE_W-1:0] handle,
                             logic [DELAY_W-1:0] delay);
        timer_req_t  item;
        int unsigned target;
        item.func   = func;
        item.handle = handle;
        item.delay  = delay;
        outbox.push_back(item);
        queued_items++;
        target = queued_items;
        wait (accepted_items >= target);
    endtask

    task automatic wait_drained();
        wait (awaited_results.size() == 0);
        @(negedge clk);
    endtask

    task automatic send_random(int unsigned sched_pct);
        logic [HANDLE_W-1:0] handle;
        logic [DELAY_W-1:0]  delay;
        handle = HANDLE_W'($urandom);
        if ($urandom_range(99) >= sched_pct)
        begin
            send_item(FUNC_TICK, handle, $urandom);
        end
        else
        begin
            // wide delays only where they cannot clog the table for good
            if (slot_count >= QUEUE_DEPTH)
                delay = ($urandom_range(9) == 0) ? DELAY_NONE : $urandom;
            else if ($urandom_range(99) < 6)
                delay = DELAY_NONE;
            else if (long_waits < LONG_WAIT_MAX && $urandom_range(99) < 2)
            begin
                delay = $urandom;
                long_waits++;
            end
            else
                delay = $urandom_range(1, 24);
            send_item(FUNC_SCHEDULE, handle, delay);
        end
    endtask

    task automatic test_empty_and_rejects();
        send_item(FUNC_TICK, 16'hFFFF, DELAY_MAX);
        send_item(FUNC_SCHEDULE, 16'hFFFF, DELAY_NONE);
        wait_drained();
    endtask

    task automatic test_ordering_and_head();
        // the farthest deadline stays parked for the rest of the run
        send_item(FUNC_SCHEDULE, 16'h0000, DELAY_MAX);
        long_waits++;
        send_item(FUNC_SCHEDULE, 16'hFFFF, 32'd3);
        send_item(FUNC_SCHEDULE, 16'h1234, 32'd3);
        send_item(FUNC_SCHEDULE, 16'h00FF, 32'd1);
        send_item(FUNC_SCHEDULE, 16'hABCD, 32'd3);
        wait_drained();
    endtask

    task automatic test_full_table();
        while (slot_count < QUEUE_DEPTH)
            send_item(FUNC_SCHEDULE, HANDLE_W'($urandom), $urandom_range(1, 5));
        send_item(FUNC_SCHEDULE, 16'h5A5A, DELAY_MAX);
        // zero delay wins over table full
        send_item(FUNC_SCHEDULE, 16'hA5A5, DELAY_NONE);
        repeat (6) send_item(FUNC_TICK, 16'h0000, DELAY_NONE);
        wait_drained();
    endtask

    task automatic test_rsp_backpressure();
        @(posedge clk);
        hold_rsp = 1'b1;
        repeat (12) send_random(60);
        wait (!hold_rsp);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned sched_pct [6] = '{65, 30, 80, 45, 65, 35};
        for (int p = 0; p < 6; p++)
        begin
            no_idle = (p == 2);
            repeat (48) send_random(sched_pct[p]);
            wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        tick_now       = '0;
        slot_count     = 0;
        queued_items   = 0;
        accepted_items = 0;
        error_count    = 0;
        long_waits     = 0;
        no_idle        = 1'b0;
        hold_rsp       = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_deadline[i] = '0;
            slot_handle[i]   = '0;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_and_rejects();
        test_ordering_and_head();
        test_full_table();
        test_rsp_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("deadline_timer_queue verification clean");
        else
            $display("deadline_timer_queue verification failed");
        $finish;
    end

endmodule
